// ----- sv/oaid_pkg.sv -----
// Shared types and constants for the ordered array insert/delete core.
// Holds the request/response structs, codes, cell control and FSM state.
`default_nettype none
package oaid_pkg;

  // Array depth, count width and read-tree grouping; field widths are fixed by the interface
  localparam int DEPTH   = 64;
  localparam int CNT_W   = 7;
  localparam int GROUP   = 8;
  localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_POP    = 3'd1,
    FN_INSERT = 3'd2,
    FN_DELETE = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_POS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic signed [31:0] read_value;
  } rsp_t;

  // Per-cell update command
  typedef struct packed {
    logic load_val;
    logic load_left;
    logic load_right;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/ordered_array_insert_delete_core.sv -----
// Ordered array core: a chain of DEPTH cells that shift in parallel.
// Requests pass through the read tree's group registers, then the response register.
// Only one request is in flight; the FSM stalls requests in ST_READ and while a response waits.
// A new request is taken in the cycle the pending response transfers.
// Reset (rst, synchronous): count and control clear; cell words stay undefined.
`default_nettype none
module ordered_array_insert_delete_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire oaid_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output oaid_pkg::rsp_t      rsp
);
  import oaid_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       status_q, status_next;
  logic [CNT_W-1:0] rsp_count_q;
  logic             accept;
  logic             full, empty;
  logic             do_ins, do_del, rd_en;
  logic [CNT_W-1:0] ins_pos;
  cell_ctl_t        ctl [DEPTH];
  logic signed [31:0] cell_data [DEPTH];
  logic signed [31:0] rd_value;

  assign accept = req_valid && !req_stall;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // Decode the request against the current count
  always_comb begin
    status_next = STS_OK;
    count_next  = count;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    rd_en       = 1'b0;
    ins_pos     = req.position;
    unique case (req.func)
      FN_APPEND: begin
        ins_pos = count;
        if (full) begin
          status_next = STS_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      FN_POP: begin
        if (empty) begin
          status_next = STS_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      FN_INSERT: begin
        if (full) begin
          status_next = STS_FULL;
        end else if (req.position > count) begin
          status_next = STS_POS;
        end else begin
          do_ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      FN_DELETE: begin
        if (empty) begin
          status_next = STS_EMPTY;
        end else if (req.position >= count) begin
          status_next = STS_POS;
        end else begin
          do_del     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      FN_READ: begin
        if (empty) begin
          status_next = STS_EMPTY;
        end else if (req.position >= count) begin
          status_next = STS_POS;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell commands: compare each cell index with the target position
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].load_val   = accept && do_ins && (CNT_W'(i) == ins_pos);
      ctl[i].load_left  = accept && do_ins && (CNT_W'(i) > ins_pos);
      ctl[i].load_right = accept && do_del && (CNT_W'(i) >= req.position);
    end
  end

  // Chain of cells, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oaid_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .value      (req.value),
      .left_data  ((i == 0) ? req.value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? cell_data[i]
                                    : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .data       (cell_data[i])
    );
  end

  oaid_rd_tree u_rd_tree (
    .clk       (clk),
    .cell_data (cell_data),
    .position  (req.position),
    .rd_en     (accept && rd_en),
    .rd_value  (rd_value)
  );

  // State register and element count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        req_stall = rsp_stall;
        if (!rsp_stall) begin
          state_next = req_valid ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold status and count of the request in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q    <= status_next;
      rsp_count_q <= count_next;
    end
  end

  // Load the response register when the read tree finishes
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rsp.status     <= status_q;
      rsp.count      <= rsp_count_q;
      rsp.read_value <= rd_value;
    end
  end

  assign rsp_valid = (state == ST_OUT);

endmodule
`default_nettype wire

// ----- sv/oaid_cell.sv -----
// One storage cell of the element chain: holds one word and takes its
// left neighbor, right neighbor or the request value. Uses oaid_pkg.
`default_nettype none
module oaid_cell (
  input  wire logic               clk,
  input  wire oaid_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] left_data,
  input  wire logic signed [31:0] right_data,
  output logic signed [31:0]      data
);
  import oaid_pkg::*;

  // Update the stored word; hold it when no load is asked for
  always_ff @(posedge clk) begin
    if (ctl.load_val) begin
      data <= value;
    end else if (ctl.load_left) begin
      data <= left_data;
    end else if (ctl.load_right) begin
      data <= right_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/oaid_rd_tree.sv -----
// Registered OR tree that picks one cell word by position.
// First level ORs groups of cells into registers. Uses oaid_pkg.
`default_nettype none
module oaid_rd_tree (
  input  wire logic               clk,
  input  wire logic signed [31:0] cell_data [oaid_pkg::DEPTH],
  input  wire logic [6:0]         position,
  input  wire logic               rd_en,
  output logic signed [31:0]      rd_value
);
  import oaid_pkg::*;

  logic [31:0] grp_or [NGROUP];
  logic [31:0] grp_q  [NGROUP];

  // Mask each cell with its position match and OR within a group
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          if (rd_en && position == CNT_W'(g * GROUP + k)) begin
            grp_or[g] = grp_or[g] | cell_data[g * GROUP + k];
          end
        end
      end
    end
  end

  // Hold group results for the second level
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_q[g] <= grp_or[g];
    end
  end

  // Combine the registered groups
  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd_value = rd_value | grp_q[g];
    end
  end

endmodule
`default_nettype wire

// ----- sv/oaid_checker.sv -----
// Port-level checker for the ordered array core, bound to the top level.
// Uses oaid_pkg for codes and depth.
`default_nettype none
module oaid_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire oaid_pkg::rsp_t rsp
);
  import oaid_pkg::*;

  // A request transfer blocks the next cycle's transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while one is in flight");

  // A response appears only after a matching request transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("response without matching request");

  // Empty status only with no elements held
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STS_EMPTY) |-> (rsp.count == '0))
    else $error("empty status with nonzero count");

  // Full status only at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STS_FULL) |-> (rsp.count == 7'(DEPTH)))
    else $error("full status below capacity");

  // Read data is zero unless the request succeeded
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != STS_OK) |-> (rsp.read_value == '0))
    else $error("read value on failed request");

endmodule

bind ordered_array_insert_delete_core oaid_checker u_oaid_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
